/* sv/qlps_pkg.sv */
`timescale 1ns / 1ps

package qlps_pkg;

  localparam int CoordW = 32;
  localparam int SizeW  = 31;
  localparam int LevelW = 4;
  localparam int DiffW  = 34;
  localparam int MagW   = 33;
  localparam int SqW    = 62;

  localparam logic [1:0] REG_OBSERVER_X = 2'd0;
  localparam logic [1:0] REG_OBSERVER_Y = 2'd1;
  localparam logic [1:0] REG_BASE_RANGE = 2'd2;

  localparam logic KIND_SELECTED = 1'b0;
  localparam logic KIND_CHILD    = 1'b1;

  typedef struct packed {
    logic [LevelW-1:0]        patch_level;
    logic signed [CoordW-1:0] patch_x;
    logic signed [CoordW-1:0] patch_y;
    logic [SizeW-1:0]         patch_size;
  } in_t;

  typedef struct packed {
    logic                     kind;
    logic [LevelW-1:0]        out_level;
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic [SizeW-1:0]         out_size;
    logic                     last;
  } out_t;

endpackage

/* sv/qlps_geom.sv */
`timescale 1ns / 1ps

// four-stage touch test: offsets, magnitudes, squares, compare
module qlps_geom #(
  parameter int MAX_LEVEL = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  qlps_pkg::in_t                       data_i,
  input  logic signed [qlps_pkg::CoordW-1:0]  obs_x_i,
  input  logic signed [qlps_pkg::CoordW-1:0]  obs_y_i,
  input  logic [qlps_pkg::SizeW-1:0]          base_range_i,
  output logic                                valid_o,
  output qlps_pkg::in_t                       data_o,
  output logic                                sel_o
);

  localparam int DW = qlps_pkg::DiffW;
  localparam int MW = qlps_pkg::MagW;
  localparam int SW = qlps_pkg::SizeW;
  localparam int QW = qlps_pkg::SqW;
  localparam int RangeW = SW + 15;

  // stage 1
  logic                 v1_q;
  qlps_pkg::in_t        p1_q, p1_d;
  logic [SW-1:0]        r1_q, r1_d;
  logic signed [DW-1:0] dx0_q, dx1_q, dy0_q, dy1_q;
  logic signed [DW-1:0] dx0_d, dx1_d, dy0_d, dy1_d;
  logic [RangeW-1:0]    rng_w;

  always_comb begin
    p1_d = data_i;
    if (int'(data_i.patch_level) > MAX_LEVEL) begin
      p1_d.patch_level = 4'(MAX_LEVEL);
    end
    rng_w = {{(RangeW-SW){1'b0}}, base_range_i} << (p1_d.patch_level - 4'd1);
    r1_d = (|rng_w[RangeW-1:SW]) ? {SW{1'b1}} : rng_w[SW-1:0];
    dx0_d = DW'(data_i.patch_x) - DW'(obs_x_i);
    dy0_d = DW'(data_i.patch_y) - DW'(obs_y_i);
    dx1_d = DW'(data_i.patch_x) + DW'({1'b0, data_i.patch_size}) - DW'(obs_x_i);
    dy1_d = DW'(data_i.patch_y) + DW'({1'b0, data_i.patch_size}) - DW'(obs_y_i);
  end

  // stage 2
  logic          v2_q;
  qlps_pkg::in_t p2_q;
  logic [SW-1:0] r2_q;
  logic [SW-1:0] ax0_q, ax1_q, ay0_q, ay1_q;
  logic [3:0]    cl2_q, cl2_d;
  logic          pre2_q, pre2_d;
  logic [MW-1:0] ax0, ax1, ay0, ay1;
  logic          ltx0, ltx1, lty0, lty1, in_sq, projx, projy, nz;

  always_comb begin
    ax0 = dx0_q[DW-1] ? MW'(-dx0_q) : dx0_q[MW-1:0];
    ax1 = dx1_q[DW-1] ? MW'(-dx1_q) : dx1_q[MW-1:0];
    ay0 = dy0_q[DW-1] ? MW'(-dy0_q) : dy0_q[MW-1:0];
    ay1 = dy1_q[DW-1] ? MW'(-dy1_q) : dy1_q[MW-1:0];
    ltx0 = ax0 < MW'(r1_q);
    ltx1 = ax1 < MW'(r1_q);
    lty0 = ay0 < MW'(r1_q);
    lty1 = ay1 < MW'(r1_q);
    nz = |p1_q.patch_size;
    // offsets are patch minus observer
    in_sq = dx0_q < 0 && dx1_q > 0 && dy0_q < 0 && dy1_q > 0;
    projx = nz && dx0_q <= 0 && dx1_q >= 0;
    projy = nz && dy0_q <= 0 && dy1_q >= 0;
    pre2_d = in_sq || (projx && (lty0 || lty1)) || (projy && (ltx0 || ltx1));
    cl2_d = {ltx1 && lty1, ltx0 && lty1, ltx1 && lty0, ltx0 && lty0};
  end

  // stage 3
  logic          v3_q;
  qlps_pkg::in_t p3_q;
  logic [3:0]    cl3_q;
  logic          pre3_q;
  logic [QW-1:0] sx0_q, sx1_q, sy0_q, sy1_q, rr_q;

  // stage 4
  logic          v4_q;
  qlps_pkg::in_t p4_q;
  logic          sel4_q, sel4_d;
  logic [QW:0]   d00, d10, d01, d11;
  logic          hit;

  always_comb begin
    d00 = {1'b0, sx0_q} + {1'b0, sy0_q};
    d10 = {1'b0, sx1_q} + {1'b0, sy0_q};
    d01 = {1'b0, sx0_q} + {1'b0, sy1_q};
    d11 = {1'b0, sx1_q} + {1'b0, sy1_q};
    hit = pre3_q
        || (cl3_q[0] && d00 < {1'b0, rr_q})
        || (cl3_q[1] && d10 < {1'b0, rr_q})
        || (cl3_q[2] && d01 < {1'b0, rr_q})
        || (cl3_q[3] && d11 < {1'b0, rr_q});
    sel4_d = (p3_q.patch_level == '0) || !hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= p1_d;
      r1_q   <= r1_d;
      dx0_q  <= dx0_d;
      dx1_q  <= dx1_d;
      dy0_q  <= dy0_d;
      dy1_q  <= dy1_d;
      p2_q   <= p1_q;
      r2_q   <= r1_q;
      ax0_q  <= ax0[SW-1:0];
      ax1_q  <= ax1[SW-1:0];
      ay0_q  <= ay0[SW-1:0];
      ay1_q  <= ay1[SW-1:0];
      cl2_q  <= cl2_d;
      pre2_q <= pre2_d;
      p3_q   <= p2_q;
      cl3_q  <= cl2_q;
      pre3_q <= pre2_q;
      sx0_q  <= QW'(ax0_q) * QW'(ax0_q);
      sx1_q  <= QW'(ax1_q) * QW'(ax1_q);
      sy0_q  <= QW'(ay0_q) * QW'(ay0_q);
      sy1_q  <= QW'(ay1_q) * QW'(ay1_q);
      rr_q   <= QW'(r2_q) * QW'(r2_q);
      p4_q   <= p3_q;
      sel4_q <= sel4_d;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = p4_q;
  assign sel_o   = sel4_q;

endmodule

/* sv/qlps_emit.sv */
`timescale 1ns / 1ps

// result register: one selected patch or four children, one per transfer
module qlps_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  qlps_pkg::in_t  data_i,
  input  logic           sel_i,
  output logic           en_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qlps_pkg::out_t out_data_o
);

  localparam int CW = qlps_pkg::CoordW;
  localparam int SW = qlps_pkg::SizeW;

  logic                 v_q;
  qlps_pkg::in_t        p_q;
  logic                 sel_q;
  logic [1:0]           cnt_q;
  logic [SW-1:0]        h_q;
  logic signed [CW-1:0] xh_q, yh_q;
  logic [SW-1:0]        h_d;
  logic                 xfer;
  qlps_pkg::out_t       o;

  assign h_d  = data_i.patch_size >> 1;
  assign xfer = v_q && !out_stall_i;

  always_comb begin
    if (sel_q) begin
      o.kind      = qlps_pkg::KIND_SELECTED;
      o.out_level = p_q.patch_level;
      o.out_x     = p_q.patch_x;
      o.out_y     = p_q.patch_y;
      o.out_size  = p_q.patch_size;
      o.last      = 1'b1;
    end else begin
      o.kind      = qlps_pkg::KIND_CHILD;
      o.out_level = p_q.patch_level - 4'd1;
      o.out_x     = cnt_q[0] ? xh_q : p_q.patch_x;
      o.out_y     = cnt_q[1] ? yh_q : p_q.patch_y;
      o.out_size  = h_q;
      o.last      = cnt_q == 2'd3;
    end
  end

  assign en_o        = !v_q || (xfer && o.last);
  assign out_valid_o = v_q;
  assign out_data_o  = o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      cnt_q <= 2'd0;
    end else if (en_o) begin
      v_q   <= valid_i;
      cnt_q <= 2'd0;
    end else if (xfer) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      p_q   <= data_i;
      sel_q <= sel_i;
      h_q   <= h_d;
      xh_q  <= data_i.patch_x + CW'(h_d);
      yh_q  <= data_i.patch_y + CW'(h_d);
    end
  end

  a_sel_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && sel_q |-> cnt_q == 2'd0)
    else $error("selected patch past first result");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !o.last |-> !en_o)
    else $error("pipeline advanced mid item");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && out_stall_i |=> v_q && $stable(cnt_q))
    else $error("result lost under stall");

endmodule

/* sv/quadtree_lod_patch_select_unit.sv */
`timescale 1ns / 1ps

// channel   dir  handshake                data
// in        in   in_valid_i / in_stall_o  in_data_i  (patch)
// out       out  out_valid_o / out_stall_i out_data_o (result)
// cfg       in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// four register stages for the touch test, then a result register
// one result leaves per cycle while out_stall_i is low: one per selected patch, four per split patch
// the result register is the bottleneck; it stalls the whole pipeline
// an input transfer passes the four touch-test stages and then the result register before its first result shows
// reset clears valid bits and loads observer 0,0 and base range 0.125
module quadtree_lod_patch_select_unit #(
  parameter int MAX_LEVEL = 15,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  qlps_pkg::in_t         in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output qlps_pkg::out_t        out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  localparam int SW = qlps_pkg::SizeW;

  // configuration registers
  logic signed [qlps_pkg::CoordW-1:0] obs_x_q, obs_y_q;
  logic [SW-1:0]                      base_range_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_x_q      <= '0;
      obs_y_q      <= '0;
      base_range_q <= SW'(1) << (FRAC_BITS - 3);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        qlps_pkg::REG_OBSERVER_X: obs_x_q      <= cfg_data_i;
        qlps_pkg::REG_OBSERVER_Y: obs_y_q      <= cfg_data_i;
        qlps_pkg::REG_BASE_RANGE: base_range_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // shared advance: the whole pipeline moves when the result register frees
  logic          en;
  logic          g_valid;
  qlps_pkg::in_t g_data;
  logic          g_sel;

  assign in_stall_o = !en;

  qlps_geom #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .data_i      (in_data_i),
    .obs_x_i     (obs_x_q),
    .obs_y_i     (obs_y_q),
    .base_range_i(base_range_q),
    .valid_o     (g_valid),
    .data_o      (g_data),
    .sel_o       (g_sel)
  );

  qlps_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (g_valid),
    .data_i     (g_data),
    .sel_i      (g_sel),
    .en_o       (en),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* tb/sv/quadtree_lod_patch_select_unit_test.sv */
`timescale 1ns / 1ps

module quadtree_lod_patch_select_unit_test;

  // index with no register behind it, writes are dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int MaxLevel = 15;
  localparam int FracBits = 16;
  localparam int RandItems = 100;   // per idling phase, four phases
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 12;  // pipeline latency plus margin
  localparam longint unsigned Max31 = 64'h7FFF_FFFF;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  qlps_pkg::in_t   in_data;
  logic            out_valid;
  logic            out_stall;
  qlps_pkg::out_t  out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [1:0]      cfg_index;
  logic [31:0]     cfg_data;

  quadtree_lod_patch_select_unit #(
    .MAX_LEVEL(MaxLevel),
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  // shadow copy of the configuration registers
  logic signed [31:0] obs_x;
  logic signed [31:0] obs_y;
  logic [30:0]        base_rng;

  qlps_pkg::out_t expected_results[$];
  int   mismatches;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_reqs;
  int   holds_done;

  // directed table: either a register write or a patch
  typedef struct {
    bit             is_cfg;
    logic [1:0]     idx;
    logic [31:0]    data;
    qlps_pkg::in_t  patch;
    bit             typed;   // want holds the single selected result
    qlps_pkg::out_t want;
  } row_t;

  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // point at offset (dx, dy) strictly inside radius r
  function automatic bit in_circle(longint dx, longint dy, longint unsigned r);
    longint unsigned ax;
    longint unsigned ay;
    ax = magnitude(dx);
    ay = magnitude(dy);
    if (ax >= r || ay >= r) return 1'b0;
    return (ax * ax + ay * ay) < (r * r);
  endfunction

  // axis-aligned edge from a0 to a0+s at cross coordinate b, observer at (ca, cb)
  function automatic bit edge_hits(longint a0, longint b, longint s, longint ca,
                                   longint cb, longint unsigned r);
    if (in_circle(a0 - ca, b - cb, r) || in_circle(a0 + s - ca, b - cb, r))
      return 1'b1;
    if (s == 0) return 1'b0;
    if (ca < a0 || ca > a0 + s) return 1'b0;
    return magnitude(b - cb) < r;
  endfunction

  // works out the results of one patch and queues them
  function automatic void predict_patch(qlps_pkg::in_t p);
    int              lvl;
    longint          px;
    longint          py;
    longint          s;
    longint          cx;
    longint          cy;
    longint          h;
    longint unsigned r;
    bit              touch;
    qlps_pkg::out_t  res;
    lvl = p.patch_level;
    px = p.patch_x;
    py = p.patch_y;
    s = longint'({1'b0, p.patch_size});
    cx = obs_x;
    cy = obs_y;
    if (lvl > MaxLevel) lvl = MaxLevel;
    touch = 1'b0;
    if (lvl != 0) begin
      r = longint'({1'b0, base_rng}) << (lvl - 1);
      if (r > Max31) r = Max31;
      touch = cx > px && cx < px + s && cy > py && cy < py + s;
      if (!touch)
        touch = edge_hits(px, py, s, cx, cy, r) || edge_hits(py, px, s, cy, cx, r) ||
                edge_hits(py, px + s, s, cy, cx, r) || edge_hits(px, py + s, s, cx, cy, r);
    end
    if (!touch) begin
      res.kind = qlps_pkg::KIND_SELECTED;
      res.out_level = lvl[3:0];
      res.out_x = p.patch_x;
      res.out_y = p.patch_y;
      res.out_size = p.patch_size;
      res.last = 1'b1;
      expected_results = {expected_results, res};
    end else begin
      h = s >>> 1;
      for (int q = 0; q < 4; q++) begin
        res.kind = qlps_pkg::KIND_CHILD;
        res.out_level = 4'(lvl - 1);
        res.out_x = 32'(px + ((q % 2) ? h : 0));   // wraps modulo 2^32
        res.out_y = 32'(py + ((q / 2) ? h : 0));
        res.out_size = h[30:0];
        res.last = (q == 3);
        expected_results = {expected_results, res};
      end
    end
  endfunction

  // ---------------------------------------------------------------- receiver
  // random stall, or a long hold-off counted here on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_reqs != holds_done) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ----------------------------------------------------------------- checker
  always @(posedge clk) begin
    qlps_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind || out_data.out_level !== want.out_level ||
            out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.out_size !== want.out_size || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // ------------------------------------------------------------------ driver
  // one patch transfer; valid only drops when a gap is drawn
  task automatic send_patch(qlps_pkg::in_t p, bit typed, qlps_pkg::out_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk iff !in_stall);
    if (typed) expected_results = {expected_results, want};
    else predict_patch(p);
  endtask

  // wait for the block to go quiet
  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // cfg_valid is dropped and held low after each write, which keeps the valid edges apart
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      qlps_pkg::REG_OBSERVER_X: obs_x = data;
      qlps_pkg::REG_OBSERVER_Y: obs_y = data;
      qlps_pkg::REG_BASE_RANGE: base_rng = data[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [31:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    rows = {rows, r};
  endtask

  // selected rows carry their expected result, the rest go to the predictor
  task automatic add_patch(int lvl, logic [31:0] x, logic [31:0] y, logic [30:0] s,
                           bit typed);
    row_t r;
    r = '{default: '0};
    r.patch = '{patch_level: lvl[3:0], patch_x: x, patch_y: y, patch_size: s};
    r.typed = typed;
    r.want = '{kind: qlps_pkg::KIND_SELECTED, out_level: lvl[3:0], out_x: x, out_y: y,
               out_size: s, last: 1'b1};
    rows = {rows, r};
  endtask

  // random patch, mostly placed around the observer so both outcomes occur
  function automatic qlps_pkg::in_t random_patch();
    qlps_pkg::in_t p;
    longint        s;
    p.patch_level = 4'($urandom_range(15));
    if ($urandom_range(99) < 30) begin
      p.patch_x = $urandom;
      p.patch_y = $urandom;
      p.patch_size = 31'($urandom);
    end else begin
      case ($urandom_range(3))
        0: s = $urandom_range(7);
        1: s = $urandom_range(1 << 18);
        2: s = $urandom_range(1 << 24);
        default: s = $urandom & 32'h7FFF_FFFF;
      endcase
      p.patch_size = s[30:0];
      p.patch_x = 32'(longint'(obs_x) - longint'($urandom_range(32'(s + 2))) + 1);
      p.patch_y = 32'(longint'(obs_y) - longint'($urandom_range(32'(s + 2))) + 1);
    end
    return p;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_range();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'd8192;
      3: return $urandom_range(1 << 20);
      default: return $urandom;   // bit 31 is dropped by the block
    endcase
  endfunction

  initial begin
    qlps_pkg::out_t none;
    qlps_pkg::in_t  p;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = qlps_pkg::REG_OBSERVER_X;
    cfg_data = '0;
    mismatches = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    holds_done = 0;
    obs_x = '0;
    obs_y = '0;
    base_rng = 31'(1 << (FracBits - 3));

    // values after reset: observer at origin, range 0.125
    add_patch(0, 32'h0, 32'h0, 31'h1_0000, 1'b1);
    add_patch(0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    add_patch(1, -32'sh1_0000, -32'sh1_0000, 31'h2_0000, 1'b0);    // observer inside
    add_patch(1, 32'h10_0000, 32'h10_0000, 31'h1_0000, 1'b1);      // far away
    add_patch(15, -32'sd100, -32'sd100, 31'd200, 1'b0);
    add_patch(3, 32'h0, 32'h0, 31'h0, 1'b0);                        // zero size
    add_patch(2, -32'sd3, -32'sd3, 31'd7, 1'b0);                    // odd size
    add_patch(1, -32'sh1_0000, 32'd4096, 31'h2_0000, 1'b0);        // projection hit
    add_patch(1, 32'd8192, -32'sh1_0000, 31'h2_0000, 1'b1);        // distance equal range
    // bit 31 of the write is dropped: zero range
    add_cfg(qlps_pkg::REG_BASE_RANGE, 32'h8000_0000);
    add_patch(1, 32'h0, 32'h0, 31'h1_0000, 1'b1);                  // observer on corner
    add_patch(1, -32'sd1, -32'sd1, 31'd2, 1'b0);
    add_cfg(qlps_pkg::REG_OBSERVER_X, 32'h7FFF_FFFF);
    add_cfg(qlps_pkg::REG_OBSERVER_Y, 32'h7FFF_FFFF);
    add_cfg(qlps_pkg::REG_BASE_RANGE, 32'h7FFF_FFFF);
    add_patch(15, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 31'h7FFF_FFFF, 1'b0); // children wrap
    add_patch(1, 32'h8000_0000, 32'h8000_0000, 31'h0, 1'b0);
    add_cfg(qlps_pkg::REG_OBSERVER_X, 32'h8000_0000);
    add_cfg(qlps_pkg::REG_OBSERVER_Y, 32'h8000_0000);
    add_cfg(qlps_pkg::REG_BASE_RANGE, 32'd8192);
    add_patch(7, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
    add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    add_patch(1, $urandom, $urandom, 31'($urandom), 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_patch(rows[i].patch, rows[i].typed, rows[i].want);
      end
    end

    // idling phases: none, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(qlps_pkg::REG_OBSERVER_X, pick_coord());
      write_reg(qlps_pkg::REG_OBSERVER_Y, pick_coord());
      write_reg(qlps_pkg::REG_BASE_RANGE, pick_range());
      send_idle_pct = (ph == 1) ? 51 : (ph == 3) ? 32 : 0;
      stall_pct = (ph == 2) ? 51 : (ph == 3) ? 32 : 0;
      for (int n = 0; n < RandItems; n++) begin
        if (ph == 0 && n == 20) hold_reqs++;   // fill up behind a long hold-off
        if (ph == 1 && n == 50) drain();       // sender pauses until all results are in
        p = random_patch();
        send_patch(p, 1'b0, none);
      end
    end

    drain();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
